/* rtl/core/task_table_scheduler_core_defines.svh */
// Assertion macros shared by the scheduler core RTL.
`ifndef TASK_TABLE_SCHEDULER_CORE_DEFINES_SVH
`define TASK_TABLE_SCHEDULER_CORE_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define TTS_ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("scheduler core check failed");

// Property checked as a non-overlapping implication from antecedent to consequent.
`define TTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler core check failed");

`endif

/* rtl/core/tts_pkg.sv */
// Types, codes and helpers of the task table scheduler core.
package tts_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int LIST_CAP      = 16;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_SCHED  = 3'd1;
   localparam logic [2:0] REQ_EXIT   = 3'd2;
   localparam logic [2:0] REQ_KILL   = 3'd3;
   localparam logic [2:0] REQ_SET    = 3'd4;
   localparam logic [2:0] REQ_WAITIN = 3'd5;
   localparam logic [2:0] REQ_OTHER  = 3'd6;
   localparam logic [2:0] REQ_LIST   = 3'd7;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_NOTFOUND = 3'd1;
   localparam logic [2:0] STAT_IDZERO   = 3'd2;
   localparam logic [2:0] STAT_CURRENT  = 3'd3;
   localparam logic [2:0] STAT_FULL     = 3'd4;
   localparam logic [2:0] STAT_HALTED   = 3'd5;
   localparam logic [2:0] STAT_IDS_OUT  = 3'd6;

   localparam logic [2:0] RS_RUN    = 3'd0;
   localparam logic [2:0] RS_READY  = 3'd1;
   localparam logic [2:0] RS_WAIT   = 3'd2;
   localparam logic [2:0] RS_WAITIN = 3'd3;
   localparam logic [2:0] RS_TERM   = 3'd4;

   localparam logic [1:0] OS_RUN   = 2'd0;
   localparam logic [1:0] OS_READY = 2'd1;
   localparam logic [1:0] OS_WAIT  = 2'd2;
   localparam logic [1:0] OS_TERM  = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] task_id;
      logic        task_type;
      logic [2:0]  new_state;
      logic [15:0] waiter_id;
      logic [6:0]  max_entries;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] result_id;
      logic        result_type;
      logic [1:0]  os_state;
      logic        answer_flag;
      logic [6:0]  live_count;
      logic        last;
   } rsp_word_type;

   function automatic logic [1:0] os_of(input logic [2:0] st);
      logic [1:0] r;
      case (st)
         RS_RUN:   r = OS_RUN;
         RS_READY: r = OS_READY;
         RS_TERM:  r = OS_TERM;
         default:  r = OS_WAIT;
      endcase
      return r;
   endfunction

   function automatic rsp_word_type mk_rsp(input logic [2:0] st, input logic [15:0] id,
                                           input logic usr, input logic [1:0] os,
                                           input logic flag, input logic lst);
      rsp_word_type r;
      r.status      = st;
      r.result_id   = id;
      r.result_type = usr;
      r.os_state    = os;
      r.answer_flag = flag;
      r.live_count  = '0;
      r.last        = lst;
      return r;
   endfunction

endpackage

/* rtl/core/tts_slot_mem.sv */
// Slot table memory: bit-masked write port, registered read port.
module tts_slot_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 44
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/core/task_table_scheduler_core.sv */
// Round-robin task table scheduler core: request sequencer over the slot memory.
//
// Takes one request at a time and answers with one result word (a list gives one
// word per entry). Tasks live in a circular list stored in a slot memory with one
// read and one write port; every list step is one memory read, one per cycle in
// the searches. Create into an empty table finishes at dispatch; otherwise it reads
// the head, then links the new slot behind the tail. Set state walks the list from
// the head to the task; kill does the same, may take another lap to wake the
// waiter, and then unlinks. Schedule reads the current task and walks the ring,
// unlinking and rereading first when the current task leaves; a list reads one
// entry per result word. Each result waits in the output register until taken;
// the next request is taken after the last result of the previous one.
// Slot occupancy lives in flip-flops, so no clearing pass follows reset.
`include "task_table_scheduler_core_defines.svh"

module task_table_scheduler_core #(
   parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tts_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tts_pkg::rsp_word_type rsp_word
);

   localparam int IW   = $clog2(MAX_TASKS);
   localparam int CW   = $clog2(MAX_TASKS + 1);
   localparam int NW   = $clog2(tts_pkg::LIST_CAP + 1);
   localparam int O_PRV = 0;
   localparam int O_NXT = IW;
   localparam int O_WT  = 2 * IW;
   localparam int O_USR = 2 * IW + 16;
   localparam int O_ST  = 2 * IW + 17;
   localparam int O_ID  = 2 * IW + 20;
   localparam int EW    = 2 * IW + 36;

   localparam logic [EW-1:0] M_PRV = EW'({IW{1'b1}}) << O_PRV;
   localparam logic [EW-1:0] M_NXT = EW'({IW{1'b1}}) << O_NXT;
   localparam logic [EW-1:0] M_WT  = EW'(16'hFFFF) << O_WT;
   localparam logic [EW-1:0] M_ST  = EW'(3'b111) << O_ST;

   typedef enum logic [17:0] {
      S_IDLE = 18'd1,     S_DISP = 18'd2,     S_CRH  = 18'd4,     S_CRP  = 18'd8,
      S_CRN  = 18'd16,    S_CUR  = 18'd32,    S_SCH  = 18'd64,    S_SFIN = 18'd128,
      S_ULK  = 18'd256,   S_ULN  = 18'd512,   S_RCUR = 18'd1024,  S_FIND = 18'd2048,
      S_FWT  = 18'd4096,  S_WIN  = 18'd8192,  S_OTC  = 18'd16384, S_OTH  = 18'd32768,
      S_LIST = 18'd65536, S_OUT  = 18'd131072
   } seq_state_type;

   seq_state_type         state_ff, state_in;
   tts_pkg::req_word_type rq_ff, rq_in;
   tts_pkg::rsp_word_type out_ff, out_in;
   logic [MAX_TASKS-1:0]  valid_ff, valid_in;
   logic [IW-1:0]         cur_ff, cur_in, head_ff, head_in;
   logic                  nonempty_ff, nonempty_in, halted_ff, halted_in;
   logic [16:0]           idc_ff, idc_in;
   logic [CW-1:0]         total_ff, total_in;
   logic                  more_ff, more_in, unl_ff, unl_in;
   logic [IW-1:0]         t_ff, t_in, u_ff, u_in, pp_ff, pp_in, sl_ff, sl_in;
   logic [EW-1:0]         ent_ff, ent_in;
   logic [15:0]           key_ff, key_in;
   logic [2:0]            cst_ff, cst_in;
   logic                  cusr_ff, cusr_in;
   logic [15:0]           cid_ff, cid_in;
   logic                  fu_ff, fu_in, fa_ff, fa_in, puu_ff, puu_in, pau_ff, pau_in;
   logic [IW-1:0]         pu_ff, pu_in, pa_ff, pa_in;
   logic [15:0]           puid_ff, puid_in, paid_ff, paid_in;
   logic [NW-1:0]         cnt_ff, cnt_in;

   logic                  mrd_en, mwr_en;
   logic [IW-1:0]         mrd_addr, mwr_addr;
   logic [EW-1:0]         mrd_data, mwr_data, mwr_mask;

   logic [15:0]           d_id, d_wt, e_wt;
   logic [2:0]            d_st;
   logic                  d_usr, e_usr;
   logic [IW-1:0]         d_nxt, e_nxt, e_prv;

   logic                  free_any;
   logic [IW-1:0]         free_slot;
   logic [6:0]            list_n;
   logic [IW-1:0]         pick_slot;
   logic [15:0]           pick_id;
   logic                  pick_usr;

   tts_slot_mem #(.DEPTH(MAX_TASKS), .WIDTH(EW)) u_slot_mem (
      .clock   (clock),
      .rd_en   (mrd_en),
      .rd_addr (mrd_addr),
      .rd_data (mrd_data),
      .wr_en   (mwr_en),
      .wr_addr (mwr_addr),
      .wr_data (mwr_data),
      .wr_mask (mwr_mask)
   );

   assign d_id  = mrd_data[O_ID +: 16];
   assign d_st  = mrd_data[O_ST +: 3];
   assign d_usr = mrd_data[O_USR];
   assign d_wt  = mrd_data[O_WT +: 16];
   assign d_nxt = mrd_data[O_NXT +: IW];
   assign e_usr = ent_ff[O_USR];
   assign e_wt  = ent_ff[O_WT +: 16];
   assign e_nxt = ent_ff[O_NXT +: IW];
   assign e_prv = ent_ff[O_PRV +: IW];

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      rsp_word            = out_ff;
      rsp_word.live_count = 7'(total_ff);
   end

   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int k = MAX_TASKS - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_any  = 1'b1;
            free_slot = IW'(k);
         end
      end
   end

   always_comb begin
      list_n = rq_ff.max_entries;
      if (list_n > 7'(total_ff)) begin
         list_n = 7'(total_ff);
      end
      if (list_n > 7'(tts_pkg::LIST_CAP)) begin
         list_n = 7'(tts_pkg::LIST_CAP);
      end
   end

   always_comb begin
      if (fu_ff) begin
         pick_slot = pu_ff;
         pick_id   = puid_ff;
         pick_usr  = puu_ff;
      end else if (cst_ff == tts_pkg::RS_READY && cusr_ff) begin
         pick_slot = cur_ff;
         pick_id   = cid_ff;
         pick_usr  = cusr_ff;
      end else if (fa_ff) begin
         pick_slot = pa_ff;
         pick_id   = paid_ff;
         pick_usr  = pau_ff;
      end else begin
         pick_slot = cur_ff;
         pick_id   = cid_ff;
         pick_usr  = cusr_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      rq_in       = rq_ff;
      out_in      = out_ff;
      valid_in    = valid_ff;
      cur_in      = cur_ff;
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      halted_in   = halted_ff;
      idc_in      = idc_ff;
      total_in    = total_ff;
      more_in     = more_ff;
      unl_in      = unl_ff;
      t_in        = t_ff;
      u_in        = u_ff;
      pp_in       = pp_ff;
      sl_in       = sl_ff;
      ent_in      = ent_ff;
      key_in      = key_ff;
      cst_in      = cst_ff;
      cusr_in     = cusr_ff;
      cid_in      = cid_ff;
      fu_in       = fu_ff;
      fa_in       = fa_ff;
      pu_in       = pu_ff;
      pa_in       = pa_ff;
      puid_in     = puid_ff;
      paid_in     = paid_ff;
      puu_in      = puu_ff;
      pau_in      = pau_ff;
      cnt_in      = cnt_ff;
      mrd_en      = 1'b0;
      mrd_addr    = '0;
      mwr_en      = 1'b0;
      mwr_addr    = '0;
      mwr_data    = '0;
      mwr_mask    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rq_in    = req_word;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            state_in = S_OUT;
            out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1);
            if (halted_ff) begin
               out_in.status = tts_pkg::STAT_HALTED;
            end else begin
               case (rq_ff.req_type)
                  tts_pkg::REQ_CREATE: begin
                     if (idc_ff[16]) begin
                        out_in.status = tts_pkg::STAT_IDS_OUT;
                     end else if (!free_any) begin
                        out_in.status = tts_pkg::STAT_FULL;
                     end else if (!nonempty_ff) begin
                        mwr_en              = 1'b1;
                        mwr_addr            = free_slot;
                        mwr_mask            = '1;
                        mwr_data            = {idc_ff[15:0], tts_pkg::RS_RUN, rq_ff.task_type,
                                               16'h0000, free_slot, free_slot};
                        valid_in[free_slot] = 1'b1;
                        head_in             = free_slot;
                        cur_in              = free_slot;
                        nonempty_in         = 1'b1;
                        total_in            = total_ff + CW'(1);
                        idc_in              = idc_ff + 17'd1;
                        out_in = tts_pkg::mk_rsp(tts_pkg::STAT_OK, idc_ff[15:0],
                                                 rq_ff.task_type, tts_pkg::OS_RUN, 1'b0, 1'b1);
                     end else begin
                        sl_in    = free_slot;
                        mrd_en   = 1'b1;
                        mrd_addr = head_ff;
                        state_in = S_CRH;
                     end
                  end
                  tts_pkg::REQ_SCHED, tts_pkg::REQ_EXIT: begin
                     if (nonempty_ff) begin
                        unl_in   = 1'b0;
                        mrd_en   = 1'b1;
                        mrd_addr = cur_ff;
                        state_in = S_CUR;
                     end
                  end
                  tts_pkg::REQ_KILL, tts_pkg::REQ_SET: begin
                     if (rq_ff.req_type == tts_pkg::REQ_KILL && rq_ff.task_id == 16'h0000) begin
                        out_in.status = tts_pkg::STAT_IDZERO;
                     end else if (nonempty_ff) begin
                        key_in   = rq_ff.task_id;
                        mrd_en   = 1'b1;
                        mrd_addr = head_ff;
                        t_in     = head_ff;
                        state_in = S_FIND;
                     end
                  end
                  tts_pkg::REQ_WAITIN: begin
                     if (nonempty_ff) begin
                        mrd_en   = 1'b1;
                        mrd_addr = head_ff;
                        t_in     = head_ff;
                        state_in = S_WIN;
                     end
                  end
                  tts_pkg::REQ_OTHER: begin
                     out_in.status = tts_pkg::STAT_OK;
                     if (nonempty_ff) begin
                        mrd_en   = 1'b1;
                        mrd_addr = cur_ff;
                        state_in = S_OTC;
                     end
                  end
                  default: begin
                     if (nonempty_ff && list_n != 7'd0) begin
                        cnt_in   = NW'(list_n);
                        mrd_en   = 1'b1;
                        mrd_addr = head_ff;
                        t_in     = head_ff;
                        state_in = S_LIST;
                     end
                  end
               endcase
            end
         end

         S_CRH: begin
            pp_in    = mrd_data[O_PRV +: IW];
            mwr_en   = 1'b1;
            mwr_addr = head_ff;
            mwr_mask = M_PRV;
            mwr_data = EW'(sl_ff) << O_PRV;
            state_in = S_CRP;
         end

         S_CRP: begin
            mwr_en   = 1'b1;
            mwr_addr = pp_ff;
            mwr_mask = M_NXT;
            mwr_data = EW'(sl_ff) << O_NXT;
            state_in = S_CRN;
         end

         S_CRN: begin
            mwr_en          = 1'b1;
            mwr_addr        = sl_ff;
            mwr_mask        = '1;
            mwr_data        = {idc_ff[15:0], tts_pkg::RS_READY, rq_ff.task_type,
                               16'h0000, head_ff, pp_ff};
            valid_in[sl_ff] = 1'b1;
            total_in        = total_ff + CW'(1);
            idc_in          = idc_ff + 17'd1;
            out_in = tts_pkg::mk_rsp(tts_pkg::STAT_OK, idc_ff[15:0], rq_ff.task_type,
                                     tts_pkg::OS_READY, 1'b0, 1'b1);
            state_in = S_OUT;
         end

         S_CUR: begin
            if (!unl_ff && (rq_ff.req_type == tts_pkg::REQ_EXIT || d_st == tts_pkg::RS_TERM)) begin
               u_in     = cur_ff;
               ent_in   = mrd_data;
               state_in = S_ULK;
            end else begin
               cusr_in = d_usr;
               cid_in  = d_id;
               cst_in  = d_st;
               fu_in   = 1'b0;
               fa_in   = 1'b0;
               if (d_st == tts_pkg::RS_RUN) begin
                  cst_in   = tts_pkg::RS_READY;
                  mwr_en   = 1'b1;
                  mwr_addr = cur_ff;
                  mwr_mask = M_ST;
                  mwr_data = EW'(tts_pkg::RS_READY) << O_ST;
               end
               if (d_nxt == cur_ff) begin
                  state_in = S_SFIN;
               end else begin
                  mrd_en   = 1'b1;
                  mrd_addr = d_nxt;
                  t_in     = d_nxt;
                  state_in = S_SCH;
               end
            end
         end

         S_SCH: begin
            if (d_st == tts_pkg::RS_READY && d_usr && !fu_ff) begin
               fu_in   = 1'b1;
               pu_in   = t_ff;
               puid_in = d_id;
               puu_in  = d_usr;
            end
            if (d_st == tts_pkg::RS_READY && !fa_ff) begin
               fa_in   = 1'b1;
               pa_in   = t_ff;
               paid_in = d_id;
               pau_in  = d_usr;
            end
            if (d_nxt == cur_ff) begin
               state_in = S_SFIN;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
               t_in     = d_nxt;
            end
         end

         S_SFIN: begin
            mwr_en   = 1'b1;
            mwr_addr = pick_slot;
            mwr_mask = M_ST;
            mwr_data = EW'(tts_pkg::RS_RUN) << O_ST;
            cur_in   = pick_slot;
            out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, pick_id, pick_usr, tts_pkg::OS_RUN,
                                       1'b0, 1'b1);
            state_in = S_OUT;
         end

         S_ULK: begin
            if (e_nxt == u_ff) begin
               valid_in[u_ff] = 1'b0;
               total_in       = total_ff - CW'(1);
               nonempty_in    = 1'b0;
               head_in        = '0;
               cur_in         = '0;
               state_in       = S_OUT;
               if (rq_ff.req_type == tts_pkg::REQ_KILL) begin
                  out_in = tts_pkg::mk_rsp(tts_pkg::STAT_OK, rq_ff.task_id, e_usr,
                                           tts_pkg::OS_TERM, 1'b0, 1'b1);
               end else begin
                  halted_in = 1'b1;
                  out_in    = tts_pkg::mk_rsp(tts_pkg::STAT_HALTED, '0, 1'b0, '0, 1'b0, 1'b1);
               end
            end else begin
               mwr_en   = 1'b1;
               mwr_addr = e_prv;
               mwr_mask = M_NXT;
               mwr_data = EW'(e_nxt) << O_NXT;
               state_in = S_ULN;
            end
         end

         S_ULN: begin
            mwr_en         = 1'b1;
            mwr_addr       = e_nxt;
            mwr_mask       = M_PRV;
            mwr_data       = EW'(e_prv) << O_PRV;
            valid_in[u_ff] = 1'b0;
            total_in       = total_ff - CW'(1);
            if (head_ff == u_ff) begin
               head_in = e_nxt;
            end
            if (cur_ff == u_ff) begin
               cur_in = e_nxt;
            end
            if (rq_ff.req_type == tts_pkg::REQ_KILL) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, rq_ff.task_id, e_usr,
                                          tts_pkg::OS_TERM, 1'b0, 1'b1);
               state_in = S_OUT;
            end else begin
               unl_in   = 1'b1;
               state_in = S_RCUR;
            end
         end

         S_RCUR: begin
            mrd_en   = 1'b1;
            mrd_addr = cur_ff;
            state_in = S_CUR;
         end

         S_FIND: begin
            if (d_id == key_ff) begin
               state_in = S_OUT;
               if (rq_ff.req_type == tts_pkg::REQ_KILL) begin
                  if (t_ff == cur_ff) begin
                     out_in = tts_pkg::mk_rsp(tts_pkg::STAT_CURRENT, rq_ff.task_id, d_usr,
                                              tts_pkg::os_of(d_st), 1'b0, 1'b1);
                  end else begin
                     u_in   = t_ff;
                     ent_in = mrd_data;
                     if (d_wt != 16'h0000) begin
                        key_in   = d_wt;
                        mrd_en   = 1'b1;
                        mrd_addr = head_ff;
                        t_in     = head_ff;
                        state_in = S_FWT;
                     end else begin
                        state_in = S_ULK;
                     end
                  end
               end else if (rq_ff.new_state > tts_pkg::RS_TERM) begin
                  out_in = tts_pkg::mk_rsp(tts_pkg::STAT_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1);
               end else begin
                  mwr_en   = 1'b1;
                  mwr_addr = t_ff;
                  mwr_mask = M_ST | M_WT;
                  mwr_data = (EW'(rq_ff.new_state) << O_ST) | (EW'(rq_ff.waiter_id) << O_WT);
                  out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, rq_ff.task_id, d_usr,
                                             tts_pkg::os_of(rq_ff.new_state), 1'b0, 1'b1);
               end
            end else if (d_nxt == head_ff) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1);
               state_in = S_OUT;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
               t_in     = d_nxt;
            end
         end

         S_FWT: begin
            if (d_id == e_wt) begin
               if (d_st == tts_pkg::RS_WAIT) begin
                  mwr_en   = 1'b1;
                  mwr_addr = t_ff;
                  mwr_mask = M_ST;
                  mwr_data = EW'(tts_pkg::RS_READY) << O_ST;
               end
               state_in = S_ULK;
            end else if (d_nxt == head_ff) begin
               state_in = S_ULK;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
               t_in     = d_nxt;
            end
         end

         S_WIN: begin
            if (d_st == tts_pkg::RS_WAITIN) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, d_id, d_usr, tts_pkg::OS_WAIT,
                                          1'b1, 1'b1);
               state_in = S_OUT;
            end else if (d_nxt == head_ff) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_NOTFOUND, '0, 1'b0, '0, 1'b0, 1'b1);
               state_in = S_OUT;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
               t_in     = d_nxt;
            end
         end

         S_OTC: begin
            if (d_nxt == cur_ff) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, '0, 1'b0, '0, 1'b0, 1'b1);
               state_in = S_OUT;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
               state_in = S_OTH;
            end
         end

         S_OTH: begin
            if (d_usr && d_st == tts_pkg::RS_READY) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, '0, 1'b0, '0, 1'b1, 1'b1);
               state_in = S_OUT;
            end else if (d_nxt == cur_ff) begin
               out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, '0, 1'b0, '0, 1'b0, 1'b1);
               state_in = S_OUT;
            end else begin
               mrd_en   = 1'b1;
               mrd_addr = d_nxt;
            end
         end

         S_LIST: begin
            out_in   = tts_pkg::mk_rsp(tts_pkg::STAT_OK, d_id, d_usr, tts_pkg::os_of(d_st),
                                       1'b0, cnt_ff == NW'(1));
            t_in     = d_nxt;
            cnt_in   = cnt_ff - NW'(1);
            more_in  = (cnt_ff != NW'(1));
            state_in = S_OUT;
         end

         S_OUT: begin
            if (!rsp_stall) begin
               if (more_ff) begin
                  mrd_en   = 1'b1;
                  mrd_addr = t_ff;
                  state_in = S_LIST;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         cur_ff      <= '0;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         halted_ff   <= 1'b0;
         idc_ff      <= '0;
         total_ff    <= '0;
         more_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         cur_ff      <= cur_in;
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         halted_ff   <= halted_in;
         idc_ff      <= idc_in;
         total_ff    <= total_in;
         more_ff     <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff   <= rq_in;
      out_ff  <= out_in;
      unl_ff  <= unl_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      pp_ff   <= pp_in;
      sl_ff   <= sl_in;
      ent_ff  <= ent_in;
      key_ff  <= key_in;
      cst_ff  <= cst_in;
      cusr_ff <= cusr_in;
      cid_ff  <= cid_in;
      fu_ff   <= fu_in;
      fa_ff   <= fa_in;
      pu_ff   <= pu_in;
      pa_ff   <= pa_in;
      puid_ff <= puid_in;
      paid_ff <= paid_in;
      puu_ff  <= puu_in;
      pau_ff  <= pau_in;
      cnt_ff  <= cnt_in;
   end

   `TTS_ASSERT_HOLDS(a_total_matches_valid, clock, reset, $countones(valid_ff) == int'(total_ff))
   `TTS_ASSERT_HOLDS(a_nonempty_matches_total, clock, reset, nonempty_ff == (total_ff != '0))
   `TTS_ASSERT_HOLDS(a_current_is_live, clock, reset, !nonempty_ff || valid_ff[cur_ff])
   `TTS_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)

endmodule

/* tb/tb.sv */
// Testbench for the task table scheduler core: random and directed requests, scoreboard check.
module tb;
   import tts_pkg::*;

   class sched_scoreboard;
      bit          occupied[MAX_TASKS_DEF];
      logic [15:0] ident[MAX_TASKS_DEF];
      logic [2:0]  run_st[MAX_TASKS_DEF];
      bit          is_user[MAX_TASKS_DEF];
      logic [15:0] waiter[MAX_TASKS_DEF];
      int          nxt[MAX_TASKS_DEF];
      int          prv[MAX_TASKS_DEF];
      int          cur, head, total, errors;
      bit          nonempty, halted;
      int unsigned next_id;
      rsp_word_type pending[$];

      function new();
         foreach (occupied[i]) occupied[i] = 0;
         cur = 0; head = 0; total = 0; errors = 0;
         nonempty = 0; halted = 0; next_id = 0;
      endfunction

      function void push(logic [2:0] st, logic [15:0] id, logic ty, logic [1:0] os,
                         logic flag, logic lst);
         rsp_word_type r;
         r.status = st; r.result_id = id; r.result_type = ty; r.os_state = os;
         r.answer_flag = flag; r.live_count = total[6:0]; r.last = lst;
         pending.push_back(r);
      endfunction

      function logic [1:0] os_code(logic [2:0] s);
         if (s == RS_RUN) return OS_RUN;
         if (s == RS_READY) return OS_READY;
         if (s == RS_TERM) return OS_TERM;
         return OS_WAIT;
      endfunction

      function int slot_of(logic [15:0] id);
         for (int i = 0; i < MAX_TASKS_DEF; i++)
            if (occupied[i] && ident[i] == id) return i;
         return -1;
      endfunction

      function void unlink(int s);
         if (nxt[s] == s) begin
            nonempty = 0; head = 0; cur = 0;
         end else begin
            nxt[prv[s]] = nxt[s];
            prv[nxt[s]] = prv[s];
            if (head == s) head = nxt[s];
            if (cur == s) cur = nxt[s];
         end
         occupied[s] = 0;
         if (total > 0) total--;
      endfunction

      function logic [2:0] reschedule();
         int c, t, pick;
         bit found;
         found = 0;
         c = cur;
         if (run_st[c] == RS_TERM) begin
            unlink(c);
            if (!nonempty) begin
               halted = 1;
               return STAT_HALTED;
            end
            c = cur;
         end
         if (run_st[c] == RS_RUN) run_st[c] = RS_READY;
         pick = c; t = c;
         for (int n = 0; n < MAX_TASKS_DEF; n++) begin
            t = nxt[t];
            if (run_st[t] == RS_READY && is_user[t]) begin
               pick = t; found = 1; break;
            end
            if (t == c) break;
         end
         if (!found) begin
            t = c;
            for (int n = 0; n < MAX_TASKS_DEF; n++) begin
               t = nxt[t];
               if (run_st[t] == RS_READY) begin
                  pick = t; break;
               end
               if (t == c) break;
            end
         end
         cur = pick;
         run_st[pick] = RS_RUN;
         return STAT_OK;
      endfunction

      function void note_request(req_word_type w);
         int s, p, t, n;
         logic [2:0] st;
         bit flag, ty;
         if (halted) begin
            push(STAT_HALTED, 0, 0, 0, 0, 1);
            return;
         end
         case (w.req_type)
            REQ_CREATE: begin
               s = -1;
               for (int k = 0; k < MAX_TASKS_DEF; k++)
                  if (!occupied[k]) begin
                     s = k; break;
                  end
               if (next_id >= 65536) push(STAT_IDS_OUT, 0, 0, 0, 0, 1);
               else if (s < 0) push(STAT_FULL, 0, 0, 0, 0, 1);
               else begin
                  occupied[s] = 1;
                  ident[s] = next_id[15:0];
                  next_id++;
                  is_user[s] = w.task_type;
                  waiter[s] = 0;
                  if (!nonempty) begin
                     head = s; cur = s; nxt[s] = s; prv[s] = s;
                     run_st[s] = RS_RUN; nonempty = 1;
                  end else begin
                     run_st[s] = RS_READY;
                     nxt[s] = head;
                     prv[s] = prv[head];
                     nxt[prv[head]] = s;
                     prv[head] = s;
                  end
                  total++;
                  push(STAT_OK, ident[s], w.task_type, os_code(run_st[s]), 0, 1);
               end
            end
            REQ_SCHED, REQ_EXIT: begin
               if (!nonempty) push(STAT_NOTFOUND, 0, 0, 0, 0, 1);
               else begin
                  if (w.req_type == REQ_EXIT) run_st[cur] = RS_TERM;
                  st = reschedule();
                  if (st != STAT_OK) push(st, 0, 0, 0, 0, 1);
                  else push(STAT_OK, ident[cur], is_user[cur], OS_RUN, 0, 1);
               end
            end
            REQ_KILL: begin
               s = slot_of(w.task_id);
               if (w.task_id == 0) push(STAT_IDZERO, 0, 0, 0, 0, 1);
               else if (s < 0) push(STAT_NOTFOUND, 0, 0, 0, 0, 1);
               else if (s == cur)
                  push(STAT_CURRENT, w.task_id, is_user[s], os_code(run_st[s]), 0, 1);
               else begin
                  if (waiter[s] != 0) begin
                     p = slot_of(waiter[s]);
                     if (p >= 0 && run_st[p] == RS_WAIT) run_st[p] = RS_READY;
                  end
                  run_st[s] = RS_TERM;
                  ty = is_user[s];
                  unlink(s);
                  push(STAT_OK, w.task_id, ty, OS_TERM, 0, 1);
               end
            end
            REQ_SET: begin
               s = slot_of(w.task_id);
               if (s < 0 || w.new_state > RS_TERM) push(STAT_NOTFOUND, 0, 0, 0, 0, 1);
               else begin
                  run_st[s] = w.new_state;
                  waiter[s] = w.waiter_id;
                  push(STAT_OK, w.task_id, is_user[s], os_code(w.new_state), 0, 1);
               end
            end
            REQ_WAITIN: begin
               flag = 0;
               if (nonempty) begin
                  t = head;
                  for (n = 0; n < MAX_TASKS_DEF; n++) begin
                     if (run_st[t] == RS_WAITIN) begin
                        push(STAT_OK, ident[t], is_user[t], OS_WAIT, 1, 1);
                        flag = 1;
                        break;
                     end
                     t = nxt[t];
                     if (t == head) break;
                  end
               end
               if (!flag) push(STAT_NOTFOUND, 0, 0, 0, 0, 1);
            end
            REQ_OTHER: begin
               flag = 0;
               if (nonempty) begin
                  t = nxt[cur];
                  for (n = 0; n < MAX_TASKS_DEF && t != cur; n++) begin
                     if (is_user[t] && run_st[t] == RS_READY) begin
                        flag = 1; break;
                     end
                     t = nxt[t];
                  end
               end
               push(STAT_OK, 0, 0, 0, flag, 1);
            end
            default: begin
               n = w.max_entries;
               if (n > total) n = total;
               if (n > LIST_CAP) n = LIST_CAP;
               if (!nonempty) n = 0;
               if (n == 0) push(STAT_NOTFOUND, 0, 0, 0, 0, 1);
               t = head;
               for (int k = 0; k < n; k++) begin
                  push(STAT_OK, ident[t], is_user[t], os_code(run_st[t]), 0, k + 1 == n);
                  t = nxt[t];
               end
            end
         endcase
      endfunction

      function void compare(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(rsp_word_type r);
         rsp_word_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, r);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("status", e.status, r.status);
         compare("result_id", e.result_id, r.result_id);
         compare("result_type", e.result_type, r.result_type);
         compare("os_state", e.os_state, r.os_state);
         compare("answer_flag", e.answer_flag, r.answer_flag);
         compare("live_count", e.live_count, r.live_count);
         compare("last", e.last, r.last);
      endfunction

      function logic [15:0] live_id();
         int k;
         k = $urandom_range(MAX_TASKS_DEF - 1);
         for (int i = 0; i < MAX_TASKS_DEF; i++)
            if (occupied[(k + i) % MAX_TASKS_DEF]) return ident[(k + i) % MAX_TASKS_DEF];
         return 16'($urandom);
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_word;
   int           send_idle = 14;
   int           recv_idle = 54;
   sched_scoreboard sb = new();

   task_table_scheduler_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_word);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task send_word(req_word_type w);
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      sb.note_request(w);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task send_op(logic [2:0] op, logic [15:0] id, logic ty, logic [2:0] ns,
                logic [15:0] wid, logic [6:0] maxe);
      req_word_type w;
      w.req_type = op; w.task_id = id; w.task_type = ty;
      w.new_state = ns; w.waiter_id = wid; w.max_entries = maxe;
      send_word(w);
   endtask

   task send_random();
      req_word_type w;
      int pick;
      w = req_word_type'(46'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 22) w.req_type = REQ_CREATE;
      else if (pick < 36) w.req_type = REQ_SCHED;
      else if (pick < 44) w.req_type = REQ_EXIT;
      else if (pick < 58) w.req_type = REQ_KILL;
      else if (pick < 78) w.req_type = REQ_SET;
      else if (pick < 84) w.req_type = REQ_WAITIN;
      else if (pick < 90) w.req_type = REQ_OTHER;
      else w.req_type = REQ_LIST;
      if ($urandom_range(9) < 8) w.task_id = sb.live_id();
      if ($urandom_range(9) < 6) w.waiter_id = sb.live_id();
      if ($urandom_range(9) < 7) w.new_state = 3'($urandom_range(RS_TERM));
      if ((w.req_type == REQ_SCHED || w.req_type == REQ_EXIT) && sb.total <= 1)
         w.req_type = REQ_CREATE;
      send_word(w);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty table
      send_op(REQ_SCHED, 0, 0, 0, 0, 0);
      send_op(REQ_EXIT, 0, 0, 0, 0, 0);
      send_op(REQ_OTHER, 0, 0, 0, 0, 0);
      send_op(REQ_WAITIN, 0, 0, 0, 0, 0);
      send_op(REQ_LIST, 0, 0, 0, 0, 7'h7f);
      send_op(REQ_KILL, 0, 0, 0, 0, 0);
      send_op(REQ_KILL, 16'hffff, 0, 0, 0, 0);
      for (int i = 0; i < 17; i++) send_op(REQ_CREATE, 0, i[0], 0, 0, 0);
      send_op(REQ_LIST, 0, 0, 0, 0, 7'h7f);
      send_op(REQ_LIST, 0, 0, 0, 0, 0);
      send_op(REQ_SET, 2, 0, RS_WAIT, 0, 0);
      send_op(REQ_SET, 3, 0, RS_WAITIN, 16'hffff, 0);
      send_op(REQ_SET, 4, 0, 3'd7, 2, 0);
      send_op(REQ_SET, 5, 0, RS_READY, 2, 0);
      send_op(REQ_KILL, 5, 0, 0, 0, 0);
      send_op(REQ_KILL, 0, 0, 0, 0, 0);
      send_op(REQ_WAITIN, 0, 0, 0, 0, 0);
      send_op(REQ_OTHER, 0, 0, 0, 0, 0);
      send_op(REQ_SCHED, 0, 0, 0, 0, 0);
      send_op(REQ_EXIT, 0, 0, 0, 0, 0);
      for (int i = 0; i < 225; i++) begin
         if (i == 75) begin
            send_idle = 54; recv_idle = 14;
         end else if (i == 150) begin
            send_idle = 0; recv_idle = 0;
         end
         send_random();
      end
      // drain the table down to halted
      while (!sb.halted) send_op(REQ_EXIT, 0, 0, 0, 0, 0);
      send_op(REQ_CREATE, 0, 1, 0, 0, 0);
      send_op(REQ_LIST, 0, 0, 0, 0, 7'h10);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #60000000;
      $display("FAILURE");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_slot_mem.sv
rtl/core/task_table_scheduler_core.sv
tb/tb.sv
